// File: rtl/core/fifo_free_list_block_allocator_top_macros.svh
// assertion macros shared by the free-list allocator modules
`ifndef FIFO_FREE_LIST_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIFO_FREE_LIST_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ffba_pkg.sv
// types and constants of the free-list block allocator
package ffba_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = IDX_W + 1;
	localparam int LIMIT_W = 11;
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic finish;
		logic cfg_wr;
	} cmd_t;

endpackage

// File: rtl/core/fifo_free_list_block_allocator_top.sv
// Block allocator with a first-in-first-out free list. Each item is handled
// in an accept step and a finish step: in the cycle it is accepted the link
// memory is read at the list head (allocate) or the freed block's link is
// cleared (free), and in the next cycle head, tail and end count are updated
// and the result register is loaded; the single write port of the link
// memory sets this split, since a free writes up to two links. A new item is
// not accepted until the last one has finished. A pending result does not
// stall the input as long as it is taken by the time the next item is
// accepted. block_limit may be written at any time the block is idle;
// cfg_ready is always high. The link memory has no reset and needs no
// clearing pass: only links of freed blocks are ever read.
module fifo_free_list_block_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ffba_pkg::LIMIT_W-1:0] block_limit,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [ffba_pkg::IDX_W-1:0]   block_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ffba_pkg::IDX_W-1:0]   granted_index,
	output ffba_pkg::status_t            status
);
	import ffba_pkg::*;

	cmd_t cmd;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	ffba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.block_index   (block_index),
		.block_limit   (block_limit),
		.granted_index (granted_index),
		.status        (status)
	);

endmodule

// File: rtl/core/ffba_ctrl.sv
// controller: handshakes and two-step sequencing of each item
`include "fifo_free_list_block_allocator_top_macros.svh"

module ffba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	output ffba_pkg::cmd_t cmd
);
	import ffba_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.cfg_wr = cfg_valid;
		unique case (state_q)
			S_IDLE: begin
				// result register is free by the time the item finishes
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					cmd.take = 1'b1;
					state_d  = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	`FFBA_ASSERT_NOW(a_finish_out_free, clk, arst_n, state_q == S_FINISH, !out_valid_q, "result register busy at finish")
	`FFBA_ASSERT_NEXT(a_take_to_finish, clk, arst_n, cmd.take, state_q == S_FINISH, "accepted item not finished next cycle")
	`FFBA_ASSERT_NEXT(a_finish_result, clk, arst_n, cmd.finish, out_valid_q, "finished item gave no result")

endmodule

// File: rtl/core/ffba_dp.sv
// datapath: link memory, list head and tail, end count, limit and result register
`include "fifo_free_list_block_allocator_top_macros.svh"

module ffba_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffba_pkg::cmd_t                 cmd,
	input  logic                           opcode,
	input  logic [ffba_pkg::IDX_W-1:0]     block_index,
	input  logic [ffba_pkg::LIMIT_W-1:0]   block_limit,
	output logic [ffba_pkg::IDX_W-1:0]     granted_index,
	output ffba_pkg::status_t              status
);
	import ffba_pkg::*;

	logic [IDX_W-1:0]   link_mem [NUM_BLOCKS];
	logic [IDX_W-1:0]   link_rd_q;
	logic [IDX_W-1:0]   list_head_q;
	logic [IDX_W-1:0]   list_tail_q;
	logic [IDX_W-1:0]   idx_q;
	logic               op_free_q;
	logic [CNT_W-1:0]   end_count_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [IDX_W-1:0]   granted_q;
	status_t            status_q;

	logic               in_bad;
	logic               q_bad;
	logic [CMP_W-1:0]   limit_ext;
	logic [CMP_W-1:0]   cap;
	logic               cnt_avail;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   wr_data;
	logic [IDX_W-1:0]   res_granted;
	status_t            res_status;

	// header block and never-issued blocks cannot be freed
	assign in_bad = (block_index == '0) || (CNT_W'(block_index) >= end_count_q);
	assign q_bad  = (idx_q == '0) || (CNT_W'(idx_q) >= end_count_q);

	assign limit_ext = CMP_W'(limit_q);
	assign cap       = (limit_ext > CMP_W'(NUM_BLOCKS)) ? CMP_W'(NUM_BLOCKS) : limit_ext;
	assign cnt_avail = CMP_W'(end_count_q) < cap;

	// a free clears its own link first, then the old tail points at it
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = block_index;
		wr_data = '0;
		if (cmd.take && (opcode == OP_FREE) && !in_bad) begin
			wr_en = 1'b1;
		end else if (cmd.finish && op_free_q && !q_bad && (list_tail_q != '0)) begin
			wr_en   = 1'b1;
			wr_addr = list_tail_q;
			wr_data = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.take) begin
			link_rd_q <= link_mem[list_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_free_q <= (opcode == OP_FREE);
			idx_q     <= block_index;
		end
	end

	always_comb begin
		res_granted = '0;
		res_status  = ST_OK;
		if (!op_free_q) begin
			if (list_head_q != '0) begin
				res_granted = list_head_q;
			end else if (cnt_avail) begin
				res_granted = IDX_W'(end_count_q);
			end else begin
				res_status = ST_FULL;
			end
		end else if (q_bad) begin
			res_status = ST_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q <= '0;
			list_tail_q <= '0;
			end_count_q <= CNT_W'(1);
			limit_q     <= LIMIT_RESET;
		end else begin
			if (cmd.cfg_wr) begin
				limit_q <= block_limit;
			end
			if (cmd.finish) begin
				if (!op_free_q) begin
					if (list_head_q != '0) begin
						list_head_q <= link_rd_q;
						if (link_rd_q == '0) begin
							list_tail_q <= '0;
						end
					end else if (cnt_avail) begin
						end_count_q <= end_count_q + 1'b1;
					end
				end else if (!q_bad) begin
					if (list_tail_q != '0) begin
						list_tail_q <= idx_q;
					end else begin
						list_head_q <= idx_q;
						list_tail_q <= idx_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			granted_q <= res_granted;
			status_q  <= res_status;
		end
	end

	assign granted_index = granted_q;
	assign status        = status_q;

	`FFBA_ASSERT_NOW(a_head_tail_empty, clk, arst_n, 1'b1, (list_head_q == '0) == (list_tail_q == '0), "head and tail disagree on empty list")
	`FFBA_ASSERT_NOW(a_end_count_nonzero, clk, arst_n, 1'b1, end_count_q != '0, "end count lost the header block")

endmodule
